// ===== hdl/mlbps_pkg.sv =====
// shared types and constants for the multi-led blink pattern sequencer
// no dependencies; used by mlbps_ram users and the sequencer core
`default_nettype none

package mlbps_pkg;

   localparam int NUM_LEDS_DEF  = 8;
   localparam int MAX_STEPS_DEF = 10;
   localparam int LEVELS_W      = 8;
   localparam int TIME_W        = 32;
   localparam int DUR_W         = 16;

   typedef enum logic [2:0] {
      ACT_TICK    = 3'd0,
      ACT_ON      = 3'd1,
      ACT_OFF     = 3'd2,
      ACT_ALL_ON  = 3'd3,
      ACT_ALL_OFF = 3'd4,
      ACT_LOAD    = 3'd5,
      ACT_START   = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/mlbps_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mlbps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 80
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/multi_led_blink_pattern_sequencer_core.sv =====
// multi-led blink pattern sequencer core: commands, per-led state scan, result register
// depends on mlbps_pkg and mlbps_ram
`default_nettype none

// usage
//  - req channel carries one command item: tick, led on/off, all on/off, load step,
//    start pattern. rsp channel returns one item per command: the pin level of
//    every led after the command (bit one = pin high = led dark)
//  - both channels use valid/stall; a transfer happens when valid is high and stall low
//  - step durations live in a pattern ram (one row of MAX_STEPS entries per led);
//    step count, current step and deadline of each led live in a state ram;
//    mode and pin level of each led are flops
//  - static and load/start commands are done in the accept cycle; the result item
//    is presented once the fsm has reached ST_DONE and loaded the output register
//  - a tick walks the leds one per cycle through a three-stage read/modify/write
//    loop (state read, pattern read, write back); the single state ram read port
//    sets the pace, and the result is offered once the loop has drained
//  - one command is worked on at a time; req_stall is high while a command runs
//  - the result sits in an output register; while rsp_stall holds it, the next
//    command is still accepted and runs, then waits for the register to free up
//  - reset (synchronous, active high) puts every led in static mode, pin high;
//    the rams need no clearing since an led's state entry is always written by
//    start pattern before pattern mode can use it
`default_nettype none

module multi_led_blink_pattern_sequencer_core #(
   parameter int NUM_LEDS  = mlbps_pkg::NUM_LEDS_DEF,
   parameter int MAX_STEPS = mlbps_pkg::MAX_STEPS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // command items
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [2:0]                   req_action,
   input  wire logic [2:0]                   req_led_index,
   input  wire logic [3:0]                   req_step_index,
   input  wire logic [15:0]                  req_duration_ms,
   input  wire logic [7:0]                   req_pattern_length,
   input  wire logic [31:0]                  req_now_ms,
   // result items
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [mlbps_pkg::LEVELS_W-1:0]    rsp_led_levels
);

   // widths
   localparam int LED_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int STEP_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int CNT_W   = $clog2(MAX_STEPS + 1);
   localparam int PAT_D   = NUM_LEDS * MAX_STEPS;
   localparam int PAT_AW  = (PAT_D > 1) ? $clog2(PAT_D) : 1;
   localparam int TIME_W  = mlbps_pkg::TIME_W;
   localparam int DUR_W   = mlbps_pkg::DUR_W;
   localparam int ST_W    = CNT_W + STEP_W + TIME_W;
   localparam int LVL_W   = mlbps_pkg::LEVELS_W;

   // control state
   mlbps_pkg::state_type  state_ff, state_in;
   logic [NUM_LEDS-1:0]   mode_ff, mode_in;
   logic [NUM_LEDS-1:0]   pin_ff, pin_in;
   logic [LED_W:0]        iss_ff, iss_in;
   logic                  b_vld_ff, b_vld_in;
   logic                  c_vld_ff, c_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [LED_W-1:0]      b_led_ff, b_led_in;
   logic [LED_W-1:0]      c_led_ff, c_led_in;
   logic                  c_go_ff, c_go_in;
   logic [STEP_W-1:0]     c_next_ff, c_next_in;
   logic [CNT_W-1:0]      c_cnt_ff, c_cnt_in;
   logic [LVL_W-1:0]      rsp_lvl_ff, rsp_lvl_in;

   // ram ports
   logic                  st_wr_en;
   logic [LED_W-1:0]      st_wr_addr;
   logic [ST_W-1:0]       st_wr_data;
   logic                  st_rd_en;
   logic [LED_W-1:0]      st_rd_addr;
   logic [ST_W-1:0]       st_rd_data;
   logic                  pat_wr_en;
   logic [PAT_AW-1:0]     pat_wr_addr;
   logic                  pat_rd_en;
   logic [PAT_AW-1:0]     pat_rd_addr;
   logic [DUR_W-1:0]      pat_rd_data;

   // decoded command
   mlbps_pkg::action_type act;
   logic                  req_acc;
   logic                  led_ok;
   logic                  step_ok;
   logic [LED_W-1:0]      led_idx;
   logic [CNT_W-1:0]      len_clamp;
   logic [STEP_W-1:0]     len_last;
   logic                  scan_more;
   logic                  rsp_load;
   logic [LVL_W-1:0]      levels;

   // stage b view of the state entry
   logic [CNT_W-1:0]      b_cnt;
   logic [STEP_W-1:0]     b_cur;
   logic [TIME_W-1:0]     b_dl;
   logic [CNT_W-1:0]      b_nxt;

   assign act       = mlbps_pkg::action_type'(req_action);
   assign req_acc   = req_valid && !req_stall;
   assign led_ok    = 6'(req_led_index) < 6'(NUM_LEDS);
   assign step_ok   = 5'(req_step_index) < 5'(MAX_STEPS);
   assign led_idx   = LED_W'(req_led_index);
   assign scan_more = iss_ff < (LED_W + 1)'(NUM_LEDS);

   // clamp the pattern length to 1..MAX_STEPS
   always_comb begin
      if (req_pattern_length > 8'(MAX_STEPS)) begin
         len_clamp = CNT_W'(MAX_STEPS);
      end else if (req_pattern_length == 8'd0) begin
         len_clamp = CNT_W'(1);
      end else begin
         len_clamp = CNT_W'(req_pattern_length);
      end
      len_last = STEP_W'(len_clamp - CNT_W'(1));
   end

   // pin levels of the visible leds, absent leds read zero
   for (genvar g = 0; g < LVL_W; g++) begin : g_lvl
      if (g < NUM_LEDS) begin : g_on
         assign levels[g] = pin_ff[g];
      end else begin : g_off
         assign levels[g] = 1'b0;
      end
   end

   // ---------------------------------------------------------------- storage
   mlbps_ram #(
      .WIDTH (DUR_W),
      .DEPTH (PAT_D)
   ) u_pat_ram (
      .clock   (clock),
      .wr_en   (pat_wr_en),
      .wr_addr (pat_wr_addr),
      .wr_data (req_duration_ms),
      .rd_en   (pat_rd_en),
      .rd_addr (pat_rd_addr),
      .rd_data (pat_rd_data)
   );

   mlbps_ram #(
      .WIDTH (ST_W),
      .DEPTH (NUM_LEDS)
   ) u_st_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // ---------------------------------------------------------------- scan pipeline
   // stage a: read the state entry of led iss_ff
   assign st_rd_en   = (state_ff == mlbps_pkg::ST_SCAN) && scan_more;
   assign st_rd_addr = iss_ff[LED_W-1:0];

   // stage b: decide whether the led advances and fetch the new step's duration
   always_comb begin
      b_cnt = st_rd_data[ST_W-1 -: CNT_W];
      b_cur = st_rd_data[TIME_W +: STEP_W];
      b_dl  = st_rd_data[TIME_W-1:0];
      b_nxt = CNT_W'(b_cur) + CNT_W'(1);
      if (b_nxt >= b_cnt || b_nxt >= CNT_W'(MAX_STEPS)) begin
         c_next_in = '0;
      end else begin
         c_next_in = STEP_W'(b_nxt);
      end
      c_go_in     = mode_ff[b_led_ff] && (now_ff > b_dl);
      c_cnt_in    = b_cnt;
      c_led_in    = b_led_ff;
      pat_rd_en   = b_vld_ff;
      pat_rd_addr = PAT_AW'(b_led_ff) * PAT_AW'(MAX_STEPS) + PAT_AW'(c_next_in);
   end

   // command side effects and stage c write back
   always_comb begin
      mode_in     = mode_ff;
      pin_in      = pin_ff;
      now_in      = now_ff;
      st_wr_en    = 1'b0;
      st_wr_addr  = c_led_ff;
      st_wr_data  = {c_cnt_ff, c_next_ff, now_ff + TIME_W'(pat_rd_data)};
      pat_wr_en   = 1'b0;
      pat_wr_addr = PAT_AW'(led_idx) * PAT_AW'(MAX_STEPS) + PAT_AW'(req_step_index);
      if (req_acc) begin
         unique case (act)
            mlbps_pkg::ACT_TICK: begin
               now_in = req_now_ms;
            end
            mlbps_pkg::ACT_ON: begin
               if (led_ok) begin
                  mode_in[led_idx] = 1'b0;
                  pin_in[led_idx]  = 1'b0;
               end
            end
            mlbps_pkg::ACT_OFF: begin
               if (led_ok) begin
                  mode_in[led_idx] = 1'b0;
                  pin_in[led_idx]  = 1'b1;
               end
            end
            mlbps_pkg::ACT_ALL_ON: begin
               mode_in = '0;
               pin_in  = '0;
            end
            mlbps_pkg::ACT_ALL_OFF: begin
               mode_in = '0;
               pin_in  = '1;
            end
            mlbps_pkg::ACT_LOAD: begin
               pat_wr_en = led_ok && step_ok;
            end
            mlbps_pkg::ACT_START: begin
               if (led_ok) begin
                  // last step pending, deadline zero: first tick above zero enters step 0
                  mode_in[led_idx] = 1'b1;
                  st_wr_en         = 1'b1;
                  st_wr_addr       = led_idx;
                  st_wr_data       = {len_clamp, len_last, TIME_W'(0)};
               end
            end
            default: begin
            end
         endcase
      end
      if (c_vld_ff && c_go_ff) begin
         pin_in[c_led_ff] = c_next_ff[0];
         st_wr_en         = 1'b1;
      end
   end

   // scan sequencing
   always_comb begin
      iss_in   = iss_ff;
      b_vld_in = 1'b0;
      b_led_in = iss_ff[LED_W-1:0];
      c_vld_in = b_vld_ff;
      if (req_acc) begin
         iss_in = '0;
      end else if (st_rd_en) begin
         iss_in   = iss_ff + (LED_W + 1)'(1);
         b_vld_in = 1'b1;
      end
   end

   // ---------------------------------------------------------------- control fsm
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlbps_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = (act == mlbps_pkg::ACT_TICK) ? mlbps_pkg::ST_SCAN
                                                       : mlbps_pkg::ST_DONE;
            end
         end
         mlbps_pkg::ST_SCAN: begin
            if (!scan_more && !b_vld_ff && !c_vld_ff) begin
               state_in = mlbps_pkg::ST_DONE;
            end
         end
         mlbps_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = mlbps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mlbps_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != mlbps_pkg::ST_IDLE);
      rsp_load     = (state_ff == mlbps_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_lvl_in   = rsp_load ? levels : rsp_lvl_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_levels = rsp_lvl_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlbps_pkg::ST_IDLE;
         mode_ff      <= '0;
         pin_ff       <= '1;
         iss_ff       <= '0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pin_ff       <= pin_in;
         iss_ff       <= iss_in;
         b_vld_ff     <= b_vld_in;
         c_vld_ff     <= c_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      b_led_ff   <= b_led_in;
      c_led_ff   <= c_led_in;
      c_go_ff    <= c_go_in;
      c_next_ff  <= c_next_in;
      c_cnt_ff   <= c_cnt_in;
      rsp_lvl_ff <= rsp_lvl_in;
   end

   // ---------------------------------------------------------------- assertions
   // the scan pipeline is drained before a result is offered
   a_drained_at_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == mlbps_pkg::ST_DONE |-> !b_vld_ff && !c_vld_ff)
      else $error("scan pipeline busy while result pending");

   // stage c only ever follows stage b
   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      c_vld_ff |-> $past(b_vld_ff))
      else $error("stage c valid without stage b");

   // a scan only begins from a tick item
   a_scan_from_tick: assert property (@(posedge clock) disable iff (reset)
      req_acc && act != mlbps_pkg::ACT_TICK |=> state_ff != mlbps_pkg::ST_SCAN)
      else $error("scan started by a non-tick item");

   // scanned leds stay within the led count
   a_led_range: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff |-> (LED_W + 1)'(b_led_ff) < (LED_W + 1)'(NUM_LEDS))
      else $error("scan index beyond led count");

   // stage c writes back only while scanning
   a_wb_in_scan: assert property (@(posedge clock) disable iff (reset)
      c_vld_ff |-> state_ff == mlbps_pkg::ST_SCAN)
      else $error("write back outside a scan");

endmodule

`default_nettype wire
